FILE: design/biou_pkg.sv
package biou_pkg;

	// Width of the similarity threshold register and its reset value (about 0.8).
	localparam int THR_W = 17;
	localparam logic [THR_W-1:0] THR_RESET = 17'd52429;

	// Sequencer states, one-hot.
	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_OUTER     = 13'b0000000000010,
		S_LD_I      = 13'b0000000000100,
		S_AREA_A    = 13'b0000000001000,
		S_AREA_CAP  = 13'b0000000010000,
		S_RD_J      = 13'b0000000100000,
		S_OVL       = 13'b0000001000000,
		S_INTER     = 13'b0000010000000,
		S_UNION     = 13'b0000100000000,
		S_THR       = 13'b0001000000000,
		S_CMP       = 13'b0010000000000,
		S_EMIT_SCAN = 13'b0100000000000,
		S_EMIT_OUT  = 13'b1000000000000
	} state_t;

endpackage

FILE: design/box_iou_duplicate_suppression.sv
// Boxes load at one per cycle, and busy stays low while boxes are loaded.
// After the last box, busy is high for the suppression pass, which skips suppressed boxes
// and pairs each kept box i with every later box j, all on one shared multiplier.
// Emission then scans every stored box and presents each kept one in turn;
// each result shows for one cycle under kept_valid.
// Asynchronous reset empties the list and sets the threshold to 52429.
module box_iou_duplicate_suppression import biou_pkg::*; #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] box_x,
	input  logic [COORD_BITS-1:0] box_y,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  last_box,
	input  logic                  similarity_we,
	input  logic [THR_W-1:0]      similarity_q16,
	output logic                  kept_valid,
	output logic [COORD_BITS-1:0] kept_x,
	output logic [COORD_BITS-1:0] kept_y,
	output logic [COORD_BITS-1:0] kept_width,
	output logic [COORD_BITS-1:0] kept_height,
	output logic                  last_kept
);

	localparam int C  = COORD_BITS;
	localparam int BW = 4 * C;
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int AW = 2 * C;
	localparam int UW = AW + 1;
	localparam int PW = UW + THR_W;

	state_t state_q;

	logic [BW-1:0] box_mem [MAX_BOXES];
	logic [BW-1:0] rd_q;
	logic [IW-1:0] rd_addr;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_next;
	logic [MAX_BOXES-1:0] keep_q;
	logic [MAX_BOXES-1:0] keep_low;
	logic [MAX_BOXES-1:0] keep_wo;
	logic [IW-1:0]        i_q;
	logic [IW-1:0]        j_q;
	logic [CW-1:0]        k_q;
	logic [THR_W-1:0]     thr_q;

	logic [BW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [C-1:0]  iw_q;
	logic [C-1:0]  ih_q;
	logic [AW-1:0] area_a_q;
	logic [AW-1:0] area_b_q;
	logic [AW-1:0] inter_q;
	logic [UW-1:0] union_q;

	logic [UW-1:0]    op_a;
	logic [THR_W-1:0] op_b;
	logic [PW-1:0]    prod_q;

	logic [C:0]   ax1, bx1, ay1, by1;
	logic [C:0]   xlo, xhi, ylo, yhi;
	logic [C-1:0] iw_c, ih_c;
	logic         accept;
	logic         room;
	logic         similar;
	logic [CW-1:0] i_next, j_next;

	// Box fields in storage order: x, y, w, h from the top.
	assign accept = start && !busy;
	assign room   = count_q < CW'(MAX_BOXES);
	assign busy   = (state_q != S_IDLE);
	assign count_next = room ? CW'(count_q + 1'b1) : count_q;
	assign i_next = CW'({1'b0, i_q} + 1'b1);
	assign j_next = CW'({1'b0, j_q} + 1'b1);

	always_comb begin
		for (int b = 0; b < MAX_BOXES; b++) begin
			keep_low[b] = (CW'(b) < count_next);
		end
		keep_wo = keep_q;
		keep_wo[k_q[IW-1:0]] = 1'b0;
	end

	// Overlap spans of boxes a and b on each axis.
	always_comb begin
		ax1 = {1'b0, a_q[4*C-1:3*C]} + {1'b0, a_q[2*C-1:C]};
		bx1 = {1'b0, b_q[4*C-1:3*C]} + {1'b0, b_q[2*C-1:C]};
		ay1 = {1'b0, a_q[3*C-1:2*C]} + {1'b0, a_q[C-1:0]};
		by1 = {1'b0, b_q[3*C-1:2*C]} + {1'b0, b_q[C-1:0]};
		xlo = (a_q[4*C-1:3*C] > b_q[4*C-1:3*C]) ? {1'b0, a_q[4*C-1:3*C]}
			: {1'b0, b_q[4*C-1:3*C]};
		ylo = (a_q[3*C-1:2*C] > b_q[3*C-1:2*C]) ? {1'b0, a_q[3*C-1:2*C]}
			: {1'b0, b_q[3*C-1:2*C]};
		xhi = (ax1 < bx1) ? ax1 : bx1;
		yhi = (ay1 < by1) ? ay1 : by1;
		iw_c = (xhi > xlo) ? C'(xhi - xlo) : '0;
		ih_c = (yhi > ylo) ? C'(yhi - ylo) : '0;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_AREA_A: begin
				op_a = UW'(a_q[2*C-1:C]);
				op_b = THR_W'(a_q[C-1:0]);
			end
			S_OVL: begin
				op_a = UW'(b_q[2*C-1:C]);
				op_b = THR_W'(b_q[C-1:0]);
			end
			S_INTER: begin
				op_a = UW'(iw_q);
				op_b = THR_W'(ih_q);
			end
			S_THR: begin
				op_a = union_q;
				op_b = thr_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_OUTER:     rd_addr = i_q;
			S_AREA_CAP:  rd_addr = IW'(i_next);
			S_CMP:       rd_addr = IW'(j_next);
			S_EMIT_SCAN: rd_addr = k_q[IW-1:0];
			default:     rd_addr = i_q;
		endcase
	end

	// A zero union is never similar; otherwise inter * 65536 >= threshold * union.
	assign similar = (union_q != '0) && (PW'({inter_q, 16'b0}) >= prod_q);

	always_ff @(posedge clk) begin
		if (accept && room) begin
			box_mem[count_q[IW-1:0]] <= {box_x, box_y, box_width, box_height};
		end
		rd_q <= box_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(op_a) * PW'(op_b);
		if (state_q == S_LD_I) begin
			a_q <= rd_q;
		end
		if (state_q == S_AREA_CAP) begin
			area_a_q <= prod_q[AW-1:0];
		end
		if (state_q == S_RD_J) begin
			b_q <= rd_q;
		end
		if (state_q == S_OVL) begin
			iw_q <= iw_c;
			ih_q <= ih_c;
		end
		if (state_q == S_INTER) begin
			area_b_q <= prod_q[AW-1:0];
		end
		if (state_q == S_UNION) begin
			inter_q <= prod_q[AW-1:0];
			union_q <= UW'({1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, prod_q[AW-1:0]});
		end
		if (state_q == S_EMIT_OUT) begin
			kept_x      <= rd_q[4*C-1:3*C];
			kept_y      <= rd_q[3*C-1:2*C];
			kept_width  <= rd_q[2*C-1:C];
			kept_height <= rd_q[C-1:0];
			last_kept   <= (keep_wo == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			keep_q     <= '1;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			thr_q      <= THR_RESET;
			kept_valid <= 1'b0;
		end else begin
			kept_valid <= 1'b0;
			if (similarity_we) begin
				thr_q <= similarity_q16;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_next;
						if (last_box) begin
							keep_q  <= keep_low;
							i_q     <= '0;
							state_q <= S_OUTER;
						end
					end
				end
				S_OUTER: begin
					if (i_next >= count_q) begin
						k_q     <= '0;
						state_q <= S_EMIT_SCAN;
					end else if (!keep_q[i_q]) begin
						i_q <= IW'(i_next);
					end else begin
						state_q <= S_LD_I;
					end
				end
				S_LD_I:     state_q <= S_AREA_A;
				S_AREA_A:   state_q <= S_AREA_CAP;
				S_AREA_CAP: begin
					j_q     <= IW'(i_next);
					state_q <= S_RD_J;
				end
				S_RD_J:  state_q <= S_OVL;
				S_OVL:   state_q <= S_INTER;
				S_INTER: state_q <= S_UNION;
				S_UNION: state_q <= S_THR;
				S_THR:   state_q <= S_CMP;
				S_CMP: begin
					if (similar) begin
						keep_q[j_q] <= 1'b0;
					end
					if (j_next < count_q) begin
						j_q     <= IW'(j_next);
						state_q <= S_RD_J;
					end else begin
						i_q     <= IW'(i_next);
						state_q <= S_OUTER;
					end
				end
				S_EMIT_SCAN: begin
					if (k_q >= count_q) begin
						count_q <= '0;
						keep_q  <= '1;
						state_q <= S_IDLE;
					end else if (keep_q[k_q[IW-1:0]]) begin
						state_q <= S_EMIT_OUT;
					end else begin
						k_q <= CW'(k_q + 1'b1);
					end
				end
				S_EMIT_OUT: begin
					kept_valid <= 1'b1;
					keep_q     <= keep_wo;
					k_q        <= CW'(k_q + 1'b1);
					state_q    <= S_EMIT_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
